[rtl/core/tvq_pkg.sv]
package tvq_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 23;
  localparam int QUAL_BITS  = 24;
  localparam logic [QUAL_BITS-1:0] QUAL_MAX = {QUAL_BITS{1'b1}};

  // stages ahead of the divider, excluding the output register
  localparam int FRONT_STAGES = 12;

  typedef struct packed {
    logic vld;
    logic degen;
  } tvq_ctl_t;

endpackage

[rtl/core/tvq_mul.sv]
module tvq_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] ll_r, ll_nxt;
  logic [AL+BH-1:0] lh_r, lh_nxt;
  logic [AH+BL-1:0] hl_r, hl_nxt;
  logic [AH+BH-1:0] hh_r, hh_nxt;
  logic [PW-1:0]    p_r, p_nxt;

  always_comb begin
    ll_nxt = a[AL-1:0] * b[BL-1:0];
    lh_nxt = a[AL-1:0] * b[BW-1:BL];
    hl_nxt = a[AW-1:AL] * b[BL-1:0];
    hh_nxt = a[AW-1:AL] * b[BW-1:BL];
  end

  always_comb begin
    p_nxt = PW'(ll_r) + (PW'(lh_r) << BL) + (PW'(hl_r) << AL) + (PW'(hh_r) << (AL + BL));
  end

  always_ff @(posedge clk) begin
    ll_r <= ll_nxt;
    lh_r <= lh_nxt;
    hl_r <= hl_nxt;
    hh_r <= hh_nxt;
    p_r  <= p_nxt;
  end

  assign p = p_r;

endmodule

[rtl/core/tvq_div.sv]
module tvq_div #(
  parameter int NW   = 64,
  parameter int DENW = 48,
  parameter int QB   = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [NW-1:0]    num_i,
  input  logic [DENW-1:0]  den_i,
  input  tvq_pkg::tvq_ctl_t ctl_i,
  output logic [QB-1:0]    q_o,
  output tvq_pkg::tvq_ctl_t ctl_o
);

  localparam int RW = (NW > DENW + QB) ? NW : DENW + QB;

  logic [RW-1:0]     rin_c   [0:QB-1];
  logic [DENW-1:0]   din_c   [0:QB-1];
  logic [QB-1:0]     qin_c   [0:QB-1];
  tvq_pkg::tvq_ctl_t cin_c   [0:QB-1];
  logic [RW-1:0]     rem_nxt [0:QB-1];
  logic [QB-1:0]     q_nxt   [0:QB-1];
  logic [RW-1:0]     rem_r   [0:QB-1];
  logic [DENW-1:0]   den_r   [0:QB-1];
  logic [QB-1:0]     q_r     [0:QB-1];
  tvq_pkg::tvq_ctl_t ctl_r   [0:QB-1];

  always_comb begin
    logic [RW-1:0] trial;
    logic          ge;
    for (int g = 0; g < QB; g++) begin
      if (g == 0) begin
        rin_c[g] = RW'(num_i);
        din_c[g] = den_i;
        qin_c[g] = '0;
        cin_c[g] = ctl_i;
      end else begin
        rin_c[g] = rem_r[g-1];
        din_c[g] = den_r[g-1];
        qin_c[g] = q_r[g-1];
        cin_c[g] = ctl_r[g-1];
      end
    end
    // one quotient bit per stage, msb first
    for (int g = 0; g < QB; g++) begin
      trial      = RW'(din_c[g]) << (QB - 1 - g);
      ge         = (rin_c[g] >= trial);
      rem_nxt[g] = ge ? (rin_c[g] - trial) : rin_c[g];
      q_nxt[g]   = (qin_c[g] << 1) | QB'(ge);
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < QB; g++) begin
      rem_r[g] <= rem_nxt[g];
      den_r[g] <= din_c[g];
      q_r[g]   <= q_nxt[g];
      if (!rst_n) begin
        ctl_r[g] <= '0;
      end else begin
        ctl_r[g] <= cin_c[g];
      end
    end
  end

  assign q_o   = q_r[QB-1];
  assign ctl_o = ctl_r[QB-1];

endmodule

[rtl/core/tet_volume_edge_quality.sv]
// channel   ports                                   handshake
// request   in_ax .. in_dz_coord                    start && !busy
// result    out_quality, out_degenerate             out_valid strobe, one cycle
//
// one request per cycle; busy stays low, the pipeline never holds
// pipeline: 12 front stages, FRAC_BITS-5 divider stages, output register
// the divider pipeline (one quotient bit per stage) sets the depth
// synchronous reset clears all valid bits; requests in flight are dropped
// the receiver cannot stall; each result shows for exactly one cycle
module tet_volume_edge_quality #(
  parameter int COORD_BITS = tvq_pkg::COORD_BITS,
  parameter int FRAC_BITS  = tvq_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_ax,
  input  logic signed [COORD_BITS-1:0] in_ay,
  input  logic signed [COORD_BITS-1:0] in_az,
  input  logic signed [COORD_BITS-1:0] in_bx,
  input  logic signed [COORD_BITS-1:0] in_by,
  input  logic signed [COORD_BITS-1:0] in_bz,
  input  logic signed [COORD_BITS-1:0] in_cx,
  input  logic signed [COORD_BITS-1:0] in_cy,
  input  logic signed [COORD_BITS-1:0] in_cz,
  input  logic signed [COORD_BITS-1:0] in_dx_coord,
  input  logic signed [COORD_BITS-1:0] in_dy_coord,
  input  logic signed [COORD_BITS-1:0] in_dz_coord,
  output logic                         out_valid,
  output logic [tvq_pkg::QUAL_BITS-1:0] out_quality,
  output logic                         out_degenerate
);

  localparam int CW   = COORD_BITS;
  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int LW   = PW + 2;
  localparam int XW   = PW + 1;
  localparam int TW   = EW + XW;
  localparam int DW   = TW + 2;
  localparam int MW   = LW;
  localparam int D2W  = 2 * DW;
  localparam int M2W  = 2 * MW;
  localparam int M3W  = 3 * MW;
  localparam int NA   = D2W + FRAC_BITS + 1;
  localparam int NB   = M3W + 6;
  localparam int NW   = ((NA > NB) ? NA : NB) + 1;
  localparam int DENW = M3W + 7;
  localparam int QB   = FRAC_BITS - 5;
  localparam int QX   = QB + 7;
  localparam int QBW  = tvq_pkg::QUAL_BITS;
  localparam int QY   = ((QX > QBW) ? QX : QBW) + 1;
  localparam int NST  = tvq_pkg::FRONT_STAGES;

  tvq_pkg::tvq_ctl_t ctl_r [1:NST];

  logic signed [CW-1:0] pt_r   [0:3][0:2];
  logic signed [EW-1:0] edg_r  [0:5][0:2];
  logic signed [EW-1:0] edg_nxt[0:5][0:2];
  logic [PW-1:0]        sq_r   [0:5][0:2];
  logic [PW-1:0]        sq_nxt [0:5][0:2];
  logic signed [PW-1:0] pr_r   [0:5];
  logic signed [PW-1:0] pr_nxt [0:5];
  logic signed [EW-1:0] ex3_r  [0:2];
  logic signed [EW-1:0] ex4_r  [0:2];
  logic [LW-1:0]        len_r  [0:5];
  logic signed [XW-1:0] dx_r   [0:2];
  logic [LW-1:0]        mx_r   [0:2];
  logic signed [TW-1:0] tp_r   [0:2];
  logic [MW-1:0]        m6_r, m7_r, m8_r, m9_r;
  logic signed [DW-1:0] dv6_r;
  logic [DW-1:0]        ad7_r;
  logic [D2W-1:0]       d2_9, d10_r, d11_r;
  logic [M2W-1:0]       m2_9;
  logic [M3W-1:0]       m3_11;
  logic [NW-1:0]        num_r;
  logic [DENW-1:0]      den_r;
  logic [NW-1:0]        num_nxt;
  logic [DENW-1:0]      den_nxt;
  logic [QB-1:0]        q_div;
  tvq_pkg::tvq_ctl_t    ctl_div;
  logic [QY-1:0]        qual_full;
  logic [QBW-1:0]       qual_nxt, qual_r;
  logic                 ov_r, deg_r;

  assign busy = 1'b0;

  // edges in order ab, ac, ad, bc, bd, cd
  always_comb begin
    int n;
    n = 0;
    for (int i = 0; i < 4; i++) begin
      for (int k = i + 1; k < 4; k++) begin
        for (int j = 0; j < 3; j++) begin
          edg_nxt[n][j] = EW'(pt_r[k][j]) - EW'(pt_r[i][j]);
        end
        n = n + 1;
      end
    end
  end

  always_comb begin
    logic signed [PW-1:0] s;
    for (int n = 0; n < 6; n++) begin
      for (int j = 0; j < 3; j++) begin
        s            = edg_r[n][j] * edg_r[n][j];
        sq_nxt[n][j] = $unsigned(s);
      end
    end
    pr_nxt[0] = edg_r[1][1] * edg_r[2][2];
    pr_nxt[1] = edg_r[1][2] * edg_r[2][1];
    pr_nxt[2] = edg_r[2][1] * edg_r[0][2];
    pr_nxt[3] = edg_r[2][2] * edg_r[0][1];
    pr_nxt[4] = edg_r[0][1] * edg_r[1][2];
    pr_nxt[5] = edg_r[0][2] * edg_r[1][1];
  end

  always_comb begin
    logic [D2W-1:0] d2_sel;
    logic [M3W-1:0] m3_sel;
    d2_sel = d11_r;
    m3_sel = m3_11;
    num_nxt = (NW'(d2_sel) << (FRAC_BITS + 1)) + (NW'(m3_sel) << 5) + (NW'(m3_sel) << 2);
    den_nxt = (DENW'(m3_sel) << 6) + (DENW'(m3_sel) << 3);
  end

  always_ff @(posedge clk) begin
    pt_r[0][0] <= in_ax;
    pt_r[0][1] <= in_ay;
    pt_r[0][2] <= in_az;
    pt_r[1][0] <= in_bx;
    pt_r[1][1] <= in_by;
    pt_r[1][2] <= in_bz;
    pt_r[2][0] <= in_cx;
    pt_r[2][1] <= in_cy;
    pt_r[2][2] <= in_cz;
    pt_r[3][0] <= in_dx_coord;
    pt_r[3][1] <= in_dy_coord;
    pt_r[3][2] <= in_dz_coord;
    edg_r <= edg_nxt;
    sq_r  <= sq_nxt;
    pr_r  <= pr_nxt;
    for (int i = 0; i < 3; i++) begin
      ex3_r[i] <= edg_r[i][0];
      ex4_r[i] <= ex3_r[i];
    end
    for (int n = 0; n < 6; n++) begin
      len_r[n] <= LW'(sq_r[n][0]) + LW'(sq_r[n][1]) + LW'(sq_r[n][2]);
    end
    for (int i = 0; i < 3; i++) begin
      dx_r[i] <= XW'(pr_r[2*i]) - XW'(pr_r[2*i+1]);
      mx_r[i] <= (len_r[2*i] > len_r[2*i+1]) ? len_r[2*i] : len_r[2*i+1];
      tp_r[i] <= ex4_r[i] * dx_r[i];
    end
    if (mx_r[0] >= mx_r[1] && mx_r[0] >= mx_r[2]) begin
      m6_r <= mx_r[0];
    end else if (mx_r[1] >= mx_r[2]) begin
      m6_r <= mx_r[1];
    end else begin
      m6_r <= mx_r[2];
    end
    dv6_r <= DW'(tp_r[0]) + DW'(tp_r[1]) + DW'(tp_r[2]);
    ad7_r <= dv6_r[DW-1] ? $unsigned(-dv6_r) : $unsigned(dv6_r);
    m7_r  <= m6_r;
    m8_r  <= m7_r;
    m9_r  <= m8_r;
    d10_r <= d2_9;
    d11_r <= d10_r;
    num_r <= num_nxt;
    den_r <= den_nxt;
    qual_r <= qual_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NST; s++) begin
        ctl_r[s] <= '0;
      end
      ov_r  <= 1'b0;
      deg_r <= 1'b0;
    end else begin
      ctl_r[1].vld   <= start;
      ctl_r[1].degen <= 1'b0;
      for (int s = 2; s <= NST; s++) begin
        if (s == 7) begin
          ctl_r[s].vld   <= ctl_r[s-1].vld;
          ctl_r[s].degen <= (m6_r == '0);
        end else begin
          ctl_r[s] <= ctl_r[s-1];
        end
      end
      ov_r  <= ctl_div.vld;
      deg_r <= ctl_div.degen;
    end
  end

  tvq_mul #(.AW(DW), .BW(DW)) u_mul_dd (
    .clk (clk),
    .a   (ad7_r),
    .b   (ad7_r),
    .p   (d2_9)
  );

  tvq_mul #(.AW(MW), .BW(MW)) u_mul_mm (
    .clk (clk),
    .a   (m7_r),
    .b   (m7_r),
    .p   (m2_9)
  );

  tvq_mul #(.AW(M2W), .BW(MW)) u_mul_m3 (
    .clk (clk),
    .a   (m2_9),
    .b   (m9_r),
    .p   (m3_11)
  );

  tvq_div #(.NW(NW), .DENW(DENW), .QB(QB)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .num_i (num_r),
    .den_i (den_r),
    .ctl_i (ctl_r[NST]),
    .q_o   (q_div),
    .ctl_o (ctl_div)
  );

  always_comb begin
    qual_full = (QY'(q_div) << 6) + (QY'(q_div) << 3);
    if (ctl_div.degen) begin
      qual_nxt = '0;
    end else if (qual_full > QY'(tvq_pkg::QUAL_MAX)) begin
      qual_nxt = tvq_pkg::QUAL_MAX;
    end else begin
      qual_nxt = QBW'(qual_full);
    end
  end

  assign out_valid      = ov_r;
  assign out_quality    = qual_r;
  assign out_degenerate = deg_r;

endmodule

[rtl/core/tvq_checker.sv]
module tvq_checker #(
  parameter int LAT = tvq_pkg::FRAC_BITS + 8
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  start,
  input logic                                  busy,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_ax,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_ay,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_az,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_bx,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_by,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_bz,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_cx,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_cy,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_cz,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_dx_coord,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_dy_coord,
  input logic [tvq_pkg::COORD_BITS-1:0]        in_dz_coord,
  input logic                                  out_valid,
  input logic [tvq_pkg::QUAL_BITS-1:0]         out_quality,
  input logic                                  out_degenerate
);

  logic same_pts;

  assign same_pts = (in_ax == in_bx) && (in_ay == in_by) && (in_az == in_bz) &&
                    (in_ax == in_cx) && (in_ay == in_cy) && (in_az == in_cz) &&
                    (in_ax == in_dx_coord) && (in_ay == in_dy_coord) &&
                    (in_az == in_dz_coord);

  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without request");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |-> (out_quality == '0))
    else $error("degenerate result with nonzero quality");

  a_coincide: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && same_pts) |-> ##LAT (out_valid && out_degenerate))
    else $error("coincident corners not flagged");

endmodule

bind tet_volume_edge_quality tvq_checker #(.LAT(tvq_pkg::FRAC_BITS + 8)) u_tvq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_ax          (in_ax),
  .in_ay          (in_ay),
  .in_az          (in_az),
  .in_bx          (in_bx),
  .in_by          (in_by),
  .in_bz          (in_bz),
  .in_cx          (in_cx),
  .in_cy          (in_cy),
  .in_cz          (in_cz),
  .in_dx_coord    (in_dx_coord),
  .in_dy_coord    (in_dy_coord),
  .in_dz_coord    (in_dz_coord),
  .out_valid      (out_valid),
  .out_quality    (out_quality),
  .out_degenerate (out_degenerate)
);

[test/tb_tet_volume_edge_quality.sv]
`timescale 1ns / 100ps

module tb_tet_volume_edge_quality;

  localparam int CW = tvq_pkg::COORD_BITS;
  localparam int QW = tvq_pkg::QUAL_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 1850;

  typedef logic signed [CW-1:0] coord_t;
  typedef coord_t corners_t [12];

  typedef struct packed {
    logic [QW-1:0] quality;
    logic          degenerate;
  } quality_t;

  typedef struct {
    corners_t pts;
    logic     has_fixed;
    quality_t fixed;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t in_ax = '0, in_ay = '0, in_az = '0, in_bx = '0, in_by = '0, in_bz = '0;
  coord_t in_cx = '0, in_cy = '0, in_cz = '0;
  coord_t in_dx_coord = '0, in_dy_coord = '0, in_dz_coord = '0;
  logic out_valid;
  logic [QW-1:0] out_quality;
  logic out_degenerate;

  quality_t pending_q[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  stim_row_t rows[$];

  tet_volume_edge_quality dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz),
    .in_cx(in_cx), .in_cy(in_cy), .in_cz(in_cz),
    .in_dx_coord(in_dx_coord), .in_dy_coord(in_dy_coord), .in_dz_coord(in_dz_coord),
    .out_valid(out_valid), .out_quality(out_quality), .out_degenerate(out_degenerate)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // volume-to-longest-edge quality, exact integer math
  function automatic quality_t tet_quality(input corners_t c);
    quality_t r;
    logic signed [63:0] p[4][3];
    logic signed [63:0] e[3][3];
    logic signed [63:0] m, l, d1, d2, d3, dx, dy, dz;
    logic signed [127:0] trip;
    logic [255:0] num, den, m3;
    logic [63:0] q, qual;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 3; j++)
        p[i][j] = 64'(c[i*3+j]);
    m = '0;
    for (int i = 0; i < 4; i++)
      for (int k = i + 1; k < 4; k++) begin
        dx = p[k][0] - p[i][0];
        dy = p[k][1] - p[i][1];
        dz = p[k][2] - p[i][2];
        l = dx*dx + dy*dy + dz*dz;
        if (l > m) m = l;
      end
    if (m == 0) begin
      r.quality = '0;
      r.degenerate = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        e[i][j] = p[i+1][j] - p[0][j];
    d1 = e[1][1]*e[2][2] - e[1][2]*e[2][1];
    d2 = e[2][1]*e[0][2] - e[2][2]*e[0][1];
    d3 = e[0][1]*e[1][2] - e[0][2]*e[1][1];
    trip = 128'(e[0][0])*128'(d1) + 128'(e[1][0])*128'(d2) + 128'(e[2][0])*128'(d3);
    if (trip < 0) trip = -trip;
    q = '0;
    if (trip != 0) begin
      m3 = 256'(m) * 256'(m) * 256'(m);
      num = ((256'(trip) * 256'(trip)) << (tvq_pkg::FRAC_BITS + 1)) + m3 * 36;
      den = m3 * 72;
      q = 64'(num / den);
    end
    qual = 64'(72 * q);
    if (qual > 64'(tvq_pkg::QUAL_MAX)) qual = 64'(tvq_pkg::QUAL_MAX);
    r.quality = qual[QW-1:0];
    r.degenerate = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin
    quality_t exp_q;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        report("result with nothing pending");
      end else begin
        exp_q = pending_q.pop_front();
        if (out_quality !== exp_q.quality)
          report($sformatf("quality %0d, predicted %0d", out_quality, exp_q.quality));
        if (out_degenerate !== exp_q.degenerate)
          report($sformatf("degenerate %0b, predicted %0b", out_degenerate, exp_q.degenerate));
      end
    end
  end

  task automatic send_request(input corners_t c, input logic has_fixed, input quality_t fixed);
    quality_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    {in_ax, in_ay, in_az} <= {c[0], c[1], c[2]};
    {in_bx, in_by, in_bz} <= {c[3], c[4], c[5]};
    {in_cx, in_cy, in_cz} <= {c[6], c[7], c[8]};
    {in_dx_coord, in_dy_coord, in_dz_coord} <= {c[9], c[10], c[11]};
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = tet_quality(c);
    if (has_fixed && (pred !== fixed))
      report($sformatf("table row disagrees with predictor: %0d", pred.quality));
    pending_q.push_back(has_fixed ? fixed : pred);
  endtask

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(64) - 32);
      2: return $urandom_range(1) ? coord_t'(16'h7fff) : coord_t'(16'h8000);
      default: return coord_t'($urandom_range(2000) - 1000);
    endcase
  endfunction

  function automatic corners_t rand_tet();
    corners_t c;
    int mode, shape;
    mode = $urandom_range(3);
    shape = $urandom_range(9);
    for (int i = 0; i < 12; i++) c[i] = rand_coord(mode);
    if (shape == 0) begin
      // coincident corners
      for (int i = 3; i < 12; i++) c[i] = c[i % 3];
    end else if (shape == 1) begin
      // flat: all z equal
      c[5] = c[2]; c[8] = c[2]; c[11] = c[2];
    end else if (shape == 2) begin
      // two corners shared
      c[9] = c[0]; c[10] = c[1]; c[11] = c[2];
    end
    return c;
  endfunction

  function automatic stim_row_t mk(input int v[12], input logic has_fixed,
                                  input int fq, input logic fd);
    stim_row_t r;
    for (int i = 0; i < 12; i++) r.pts[i] = coord_t'(v[i]);
    r.has_fixed = has_fixed;
    r.fixed.quality = QW'(fq);
    r.fixed.degenerate = fd;
    return r;
  endfunction

  initial begin
    quality_t none;
    none = '{default: '0};
    rows.push_back(mk('{0,0,0, 0,0,0, 0,0,0, 0,0,0}, 1, 0, 1));
    rows.push_back(mk('{-32768,-32768,-32768, -32768,-32768,-32768,
                        -32768,-32768,-32768, -32768,-32768,-32768}, 1, 0, 1));
    rows.push_back(mk('{32767,32767,32767, 32767,32767,32767,
                        32767,32767,32767, 32767,32767,32767}, 1, 0, 1));
    // regular tetrahedron on cube corners
    rows.push_back(mk('{1,1,1, 1,-1,-1, -1,1,-1, -1,-1,1}, 1, 8388576, 0));
    rows.push_back(mk('{32767,32767,32767, 32767,-32767,-32767,
                        -32767,32767,-32767, -32767,-32767,32767}, 1, 8388576, 0));
    // flat
    rows.push_back(mk('{0,0,0, 1,0,0, 0,1,0, 1,1,0}, 1, 0, 0));
    rows.push_back(mk('{0,0,0, 5,5,5, 10,10,10, -3,-3,-3}, 1, 0, 0));
    rows.push_back(mk('{0,0,0, 0,0,0, 0,0,0, 1,0,0}, 1, 0, 0));
    rows.push_back(mk('{0,0,0, 1,0,0, 0,1,0, 0,0,1}, 0, 0, 0));
    rows.push_back(mk('{0,0,0, 1,0,0, 0,1,0, 0,0,-1}, 0, 0, 0));
    rows.push_back(mk('{-32768,-32768,-32768, 32767,-32768,-32768,
                        -32768,32767,-32768, -32768,-32768,32767}, 0, 0, 0));
    rows.push_back(mk('{32767,-32768,0, -32768,32767,0, 0,0,32767, 0,0,-32768}, 0, 0, 0));
    rows.push_back(mk('{0,0,0, 1,0,0, 0,1,0, 0,0,32767}, 0, 0, 0));
    rows.push_back(mk('{3,0,0, 0,3,0, 0,0,3, 1,1,1}, 0, 0, 0));
    rows.push_back(mk('{-1,-1,-1, -2,-1,-1, -1,-3,-1, -1,-1,-4}, 0, 0, 0));
    rows.push_back(mk('{21845,-21846,0, -1,1,-32768, 100,200,300, -5,7,-9}, 0, 0, 0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_request(rows[i].pts, rows[i].has_fixed, rows[i].fixed);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 34 : (phase == 1) ? 72 : 0;
      for (int n = 0; n < RANDOM_REQUESTS / 3; n++) send_request(rand_tet(), 1'b0, none);
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (tvq_pkg::FRAC_BITS + 16) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tvq_pkg.sv
rtl/core/tvq_mul.sv
rtl/core/tvq_div.sv
rtl/core/tet_volume_edge_quality.sv
rtl/core/tvq_checker.sv
test/tb_tet_volume_edge_quality.sv
